[src/assert_macros.svh]
// Assertion macros shared by the reorder buffer modules.
// Depends on a clock named aclk and an active-low reset named aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked on every rising edge of aclk while out of reset.
`define SORB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every rising edge of aclk, also during reset.
`define SORB_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`else

`define SORB_ASSERT(label, prop, msg)
`define SORB_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

[src/sorb_pkg.sv]
// Shared constants, types and helpers of the sequence reorder buffer.
// No dependencies; imported by sequence_reorder_buffer and sorb_out_reg.
package sorb_pkg;

    localparam int WINDOW_DEPTH  = 16;
    localparam int PAYLOAD_WIDTH = 32;
    localparam int SEQ_WIDTH     = 16;
    localparam int SLOT_WIDTH    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int DATA_WIDTH    = ((SEQ_WIDTH + PAYLOAD_WIDTH + 7) / 8) * 8;

    // Result kinds carried on the output tuser.
    localparam logic KIND_RELEASE = 1'b0;
    localparam logic KIND_REJECT  = 1'b1;

    typedef logic [SLOT_WIDTH-1:0]    slot_t;
    typedef logic [SEQ_WIDTH-1:0]     seq_t;
    typedef logic [PAYLOAD_WIDTH-1:0] payload_t;

    typedef struct packed {
        logic     kind;
        seq_t     seq;
        payload_t payload;
        logic     last;
    } result_t;

    // Next slot index, wrapping at the end of the window.
    function automatic slot_t slot_inc(input slot_t s);
        slot_t r;
        if (s == SLOT_WIDTH'(WINDOW_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = s + 1'b1;
        end
        return r;
    endfunction

endpackage

[src/sorb_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module sorb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/sorb_out_reg.sv]
// Output register of the reorder buffer: holds one result item for the master side.
// Depends on sorb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sorb_out_reg
    import sorb_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  load,
    input  result_t               item,
    output logic                  free,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [DATA_WIDTH-1:0] m_tdata,   // out_sequence, out_payload, zero fill
    output logic                  m_tuser,   // result_kind
    output logic                  m_tlast    // last_of_run
);

    logic    valid_reg;
    logic    valid_next;
    result_t item_reg;

    // The register can take a new item when empty or when its item leaves now.
    assign free = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= item;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = DATA_WIDTH'({item_reg.payload, item_reg.seq});
    assign m_tuser  = item_reg.kind;
    assign m_tlast  = item_reg.last;

    `SORB_ASSERT(a_reject_is_last, (m_tvalid && m_tuser == KIND_REJECT) |-> m_tlast, "reject item without tlast")
    `SORB_ASSERT(a_load_only_when_free, load |-> free, "output register overwritten")
    `SORB_ASSERT_ALWAYS(a_empty_after_reset, !aresetn |=> !m_tvalid, "output valid after reset")

endmodule

[src/sequence_reorder_buffer.sv]
// Top level of the sequence reorder buffer: window control, valid bits and
// expected sequence. Depends on sorb_pkg, sorb_ram, sorb_out_reg, assert_macros.svh.
//
// Channel   Dir  Handshake            Contents
// s_*       in   s_tvalid / s_tready  tdata: item_sequence, item_payload
// m_*       out  m_tvalid / m_tready  tdata: out_sequence, out_payload;
//                                     tuser: result_kind; tlast: last_of_run
// cfg_*     in   cfg_wen              cfg_wdata: deliver_enable
//
// An item outside the window yields one reject item.
// An item inside the window is stored, then the head slot is checked, then
// the in-order run is released item by item, paced by the single read port of
// the payload RAM and its registered read data.
// With delivery off, released slots are freed at one per cycle without output.
// Reset (aresetn low, synchronous) clears valid bits, the expected sequence,
// the head slot, the output register and deliver_enable; no clearing pass is run.
// A stalled master side holds release at the output register; the input side
// is taken only while idle and while the output register can take an item.
`include "assert_macros.svh"

module sequence_reorder_buffer
    import sorb_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration.
    input  logic                  cfg_wen,
    input  logic                  cfg_wdata,  // deliver_enable
    // Input items.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [DATA_WIDTH-1:0] s_tdata,    // item_sequence, item_payload, zero fill
    // Result items.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [DATA_WIDTH-1:0] m_tdata,    // out_sequence, out_payload, zero fill
    output logic                  m_tuser,    // result_kind
    output logic                  m_tlast     // last_of_run
);

    // Control states.
    localparam logic [1:0] ST_IDLE  = 2'd0;  // waiting for an input item
    localparam logic [1:0] ST_SCAN  = 2'd1;  // checking the head slot
    localparam logic [1:0] ST_FETCH = 2'd2;  // head payload in RAM read register

    logic [1:0]              state_reg, state_next;
    logic                    deliver_reg, deliver_next;
    seq_t                    expected_reg, expected_next;
    slot_t                   head_reg, head_next;
    logic [WINDOW_DEPTH-1:0] slot_valid_reg, slot_valid_next;

    // Input fields.
    seq_t     in_sequence;
    payload_t in_payload;
    assign in_sequence = s_tdata[SEQ_WIDTH-1:0];
    assign in_payload  = s_tdata[SEQ_WIDTH +: PAYLOAD_WIDTH];

    // Window position of the arriving item. The distance is taken modulo the
    // sequence space, so sequences behind the expected one land far outside.
    seq_t                distance;
    logic                in_window;
    logic [SLOT_WIDTH:0] slot_sum;
    slot_t               in_slot;

    assign distance  = in_sequence - expected_reg;
    assign in_window = distance < SEQ_WIDTH'(WINDOW_DEPTH);
    assign slot_sum  = {1'b0, head_reg} + {1'b0, distance[SLOT_WIDTH-1:0]};
    assign in_slot   = (slot_sum >= (SLOT_WIDTH + 1)'(WINDOW_DEPTH))
                       ? SLOT_WIDTH'(slot_sum - (SLOT_WIDTH + 1)'(WINDOW_DEPTH))
                       : slot_sum[SLOT_WIDTH-1:0];

    slot_t    head_inc;
    logic     head_valid;
    logic     next_valid;
    assign head_inc   = slot_inc(head_reg);
    assign head_valid = slot_valid_reg[head_reg];
    assign next_valid = slot_valid_reg[head_inc];

    // Payload RAM and output register.
    logic     ram_we;
    logic     ram_re;
    slot_t    ram_raddr;
    payload_t ram_rdata;
    logic     out_free;
    logic     out_load;
    result_t  out_item;
    logic     accept;

    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;
    assign ram_we   = accept && in_window;

    sorb_ram #(
        .WIDTH (PAYLOAD_WIDTH),
        .DEPTH (WINDOW_DEPTH)
    ) u_payload_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (in_slot),
        .wr_data (in_payload),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // The store in ST_IDLE and every read happen in different cycles, so a
    // read never meets a write to the same slot in flight.
    always_comb begin
        state_next      = state_reg;
        deliver_next    = deliver_reg;
        expected_next   = expected_reg;
        head_next       = head_reg;
        slot_valid_next = slot_valid_reg;
        ram_re          = 1'b0;
        ram_raddr       = head_reg;
        out_load        = 1'b0;
        out_item.kind     = KIND_RELEASE;
        out_item.seq      = expected_reg;
        out_item.payload  = ram_rdata;
        out_item.last     = !next_valid;

        if (cfg_wen) begin
            deliver_next = cfg_wdata;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (in_window) begin
                        slot_valid_next[in_slot] = 1'b1;
                        state_next               = ST_SCAN;
                    end else begin
                        out_load          = 1'b1;
                        out_item.kind     = KIND_REJECT;
                        out_item.seq      = in_sequence;
                        out_item.payload  = in_payload;
                        out_item.last     = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                if (!head_valid) begin
                    state_next = ST_IDLE;
                end else if (!deliver_reg) begin
                    // Consume silently: free the slot and move on.
                    slot_valid_next[head_reg] = 1'b0;
                    head_next                 = head_inc;
                    expected_next             = expected_reg + 1'b1;
                end else begin
                    ram_re     = 1'b1;
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: begin
                if (out_free) begin
                    out_load                  = 1'b1;
                    slot_valid_next[head_reg] = 1'b0;
                    head_next                 = head_inc;
                    expected_next             = expected_reg + 1'b1;
                    // Read the following slot straight away when it is stored.
                    if (next_valid) begin
                        ram_re    = 1'b1;
                        ram_raddr = head_inc;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            deliver_reg    <= 1'b0;
            expected_reg   <= '0;
            head_reg       <= '0;
            slot_valid_reg <= '0;
        end else begin
            state_reg      <= state_next;
            deliver_reg    <= deliver_next;
            expected_reg   <= expected_next;
            head_reg       <= head_next;
            slot_valid_reg <= slot_valid_next;
        end
    end

    sorb_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (out_load),
        .item     (out_item),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    `SORB_ASSERT(a_fetch_from_valid_slot, (state_reg == ST_FETCH) |-> head_valid, "fetch from empty slot")
    `SORB_ASSERT(a_release_advances, (state_reg == ST_FETCH && out_free) |=> (expected_reg == SEQ_WIDTH'($past(expected_reg) + 1'b1)), "expected sequence did not advance")
    `SORB_ASSERT(a_no_release_when_off, (state_reg == ST_FETCH) |-> deliver_reg, "release fetch with delivery off")

endmodule

[tb/sequence_reorder_buffer_tb.sv]
// Self-checking testbench for sequence_reorder_buffer: table-driven directed items, a short
// silent in-order run, and randomized out-of-order traffic.
// Depends on sorb_pkg and the block's RTL; expected results come from a predictor kept here.
module sequence_reorder_buffer_tb;
    import sorb_pkg::*;

    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic     kind;
        seq_t     seq;
        payload_t payload;
        logic     last;
    } outcome_t;

    typedef struct packed {
        seq_t     seq;
        payload_t payload;
        logic     typed;
        outcome_t want;
    } stim_row_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wen   = 1'b0;
    logic                  cfg_wdata = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [DATA_WIDTH-1:0] s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [DATA_WIDTH-1:0] m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;

    sequence_reorder_buffer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Predictor state: a copy of the reorder window and the delivery setting.
    logic     win_valid [WINDOW_DEPTH];
    payload_t win_payload [WINDOW_DEPTH];
    seq_t     next_seq;
    int       head_slot;
    logic     deliver_on;

    outcome_t fresh_results [$];
    outcome_t awaited_results [$];

    int  faults        = 0;
    int  results_seen  = 0;
    int  rejects_seen  = 0;
    int  items_sent    = 0;
    int  seq_wraps     = 0;
    int  sink_hold     = 0;
    bit  sink_stalls   = 1'b0;
    bit  source_gaps   = 1'b1;

    stim_row_t directed_rows [23];

    // Reject an item outside the window; else store it and release the in-order run from the head.
    function automatic void window_predict(seq_t seq, payload_t payload);
        seq_t offset;
        int   slot;
        int   n;
        offset = seq - next_seq;
        if (offset >= WINDOW_DEPTH) begin
            fresh_results.push_back('{KIND_REJECT, seq, payload, 1'b1});
            return;
        end
        slot = (head_slot + int'(offset)) % WINDOW_DEPTH;
        win_payload[slot] = payload;
        win_valid[slot] = 1'b1;
        for (n = 0; n < WINDOW_DEPTH && win_valid[head_slot]; n++) begin
            if (deliver_on) begin
                fresh_results.push_back('{KIND_RELEASE, next_seq, win_payload[head_slot], 1'b0});
            end
            win_valid[head_slot] = 1'b0;
            head_slot = (head_slot + 1) % WINDOW_DEPTH;
            next_seq = next_seq + 1'b1;
            if (next_seq == '0) begin
                seq_wraps++;
            end
        end
        if (fresh_results.size() != 0) begin
            fresh_results[fresh_results.size() - 1].last = 1'b1;
        end
    endfunction

    // Present one item and hold it until the block takes it. The handshake is
    // judged at the falling edge, where neither side can be mid-update.
    task automatic send_item(seq_t seq, payload_t payload, logic typed, outcome_t want);
        s_tvalid <= 1'b1;
        s_tdata  <= DATA_WIDTH'({payload, seq});
        do begin
            @(negedge aclk);
        end while (s_tready !== 1'b1);
        @(posedge aclk);
        items_sent++;
        fresh_results.delete();
        window_predict(seq, payload);
        if (typed) begin
            awaited_results.push_back(want);
        end else begin
            foreach (fresh_results[i]) awaited_results.push_back(fresh_results[i]);
        end
    endtask

    task automatic idle_gap();
        int r;
        int g;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            g = 0;
        end else if (r < 92) begin
            g = $urandom_range(1, 3);
        end else begin
            g = $urandom_range(8, 30);
        end
        if (source_gaps && g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    // Let the block go quiet: every result in, then room for silent releases.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_delivery(logic enable);
        cfg_wen   <= 1'b1;
        cfg_wdata <= enable;
        @(posedge aclk);
        cfg_wen    <= 1'b0;
        deliver_on = enable;
    endtask

    function automatic payload_t random_payload();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return payload_t'($urandom);
    endfunction

    // Mostly sequences inside the window, biased toward the head so runs get
    // released; the rest lands behind, just beyond, or anywhere at all.
    function automatic seq_t random_sequence();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) return next_seq + seq_t'($urandom_range(0, 3));
        if (r < 72) return next_seq + seq_t'($urandom_range(0, WINDOW_DEPTH - 1));
        if (r < 82) return next_seq - seq_t'($urandom_range(1, 40));
        if (r < 90) return next_seq + seq_t'($urandom_range(WINDOW_DEPTH, WINDOW_DEPTH + 24));
        return seq_t'($urandom);
    endfunction

    task automatic random_phase(int count);
        int   sent;
        int   k;
        bit   paused;
        seq_t base;
        sent   = 0;
        paused = 1'b0;
        while (sent < count) begin
            if ($urandom_range(0, 11) == 0) begin
                // A whole window filled back to front: the last item frees all of it.
                base = next_seq;
                for (k = WINDOW_DEPTH - 1; k >= 0; k--) begin
                    send_item(base + seq_t'(k), random_payload(), 1'b0, '0);
                    idle_gap();
                end
                sent += WINDOW_DEPTH;
            end else begin
                send_item(random_sequence(), random_payload(), 1'b0, '0);
                idle_gap();
                sent++;
            end
            if (!paused && sent >= count / 2) begin
                // Hold the source until the result side has caught up completely.
                paused = 1'b1;
                s_tvalid <= 1'b0;
                do begin
                    @(posedge aclk);
                end while (awaited_results.size() != 0);
            end
        end
    endtask

    // Result side back-pressure: bursts of ready, short stalls, now and then a long one.
    always @(posedge aclk) begin
        if (sink_hold != 0) begin
            sink_hold <= sink_hold - 1;
        end else if (!sink_stalls) begin
            m_tready <= 1'b1;
        end else begin
            m_tready  <= ($urandom_range(0, 2) != 0);
            sink_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                     : $urandom_range(0, 3);
        end
    end

    // Results are checked at the falling edge before the edge that accepts them.
    always @(negedge aclk) begin
        outcome_t got;
        outcome_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tuser, m_tdata[SEQ_WIDTH-1:0], m_tdata[SEQ_WIDTH +: PAYLOAD_WIDTH],
                    m_tlast};
            results_seen++;
            if (got.kind == KIND_REJECT) begin
                rejects_seen++;
            end
            if (awaited_results.size() == 0) begin
                faults++;
                if (faults <= 10) begin
                    $display("unexpected result: kind %0b seq %h payload %h last %0b",
                             got.kind, got.seq, got.payload, got.last);
                end
            end else begin
                want = awaited_results.pop_front();
                if (got !== want) begin
                    faults++;
                    if (faults <= 10) begin
                        $display("result mismatch: kind %0b/%0b seq %h/%h payload %h/%h last %0b/%0b",
                                 want.kind, got.kind, want.seq, got.seq,
                                 want.payload, got.payload, want.last, got.last);
                        $display("  (expected/actual)");
                    end
                end
            end
        end
    end

    initial begin
        #30_000_000;
        $display("sequence_reorder_buffer regression: fail");
        $finish;
    end

    initial begin
        for (int i = 0; i < WINDOW_DEPTH; i++) begin
            win_valid[i]   = 1'b0;
            win_payload[i] = '0;
        end
        next_seq   = '0;
        head_slot  = 0;
        deliver_on = 1'b0;

        // Rows with a typed result are single rejects or single releases; the
        // rest fill the window or release a run, and are checked by the predictor.
        directed_rows = '{
            '{16'h0000, 32'hFFFF_FFFF, 1'b1, '{KIND_RELEASE, 16'h0000, 32'hFFFF_FFFF, 1'b1}},
            '{16'h0000, 32'h0000_0000, 1'b1, '{KIND_REJECT,  16'h0000, 32'h0000_0000, 1'b1}},
            '{16'hFFFF, 32'hA5A5_A5A5, 1'b1, '{KIND_REJECT,  16'hFFFF, 32'hA5A5_A5A5, 1'b1}},
            '{16'h0011, 32'h1234_5678, 1'b1, '{KIND_REJECT,  16'h0011, 32'h1234_5678, 1'b1}},
            '{16'h0010, 32'h0000_0000, 1'b0, '0},
            '{16'h0003, 32'h1111_1111, 1'b0, '0},
            '{16'h0003, 32'h3333_3333, 1'b0, '0},
            '{16'h0002, 32'hC0DE_0002, 1'b0, '0},
            '{16'h0004, 32'hC0DE_0004, 1'b0, '0},
            '{16'h0005, 32'hC0DE_0005, 1'b0, '0},
            '{16'h0006, 32'hC0DE_0006, 1'b0, '0},
            '{16'h0007, 32'hC0DE_0007, 1'b0, '0},
            '{16'h0008, 32'hC0DE_0008, 1'b0, '0},
            '{16'h0009, 32'hC0DE_0009, 1'b0, '0},
            '{16'h000A, 32'hC0DE_000A, 1'b0, '0},
            '{16'h000B, 32'hC0DE_000B, 1'b0, '0},
            '{16'h000C, 32'hC0DE_000C, 1'b0, '0},
            '{16'h000D, 32'hC0DE_000D, 1'b0, '0},
            '{16'h000E, 32'hC0DE_000E, 1'b0, '0},
            '{16'h000F, 32'hC0DE_000F, 1'b0, '0},
            '{16'h0001, 32'h0000_0000, 1'b0, '0},
            '{16'h0011, 32'h5A5A_5A5A, 1'b1, '{KIND_RELEASE, 16'h0011, 32'h5A5A_5A5A, 1'b1}},
            '{16'h8000, 32'h0000_0000, 1'b1, '{KIND_REJECT,  16'h8000, 32'h0000_0000, 1'b1}}
        };

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed items with delivery on and a stalling result side.
        sink_stalls <= 1'b1;
        set_delivery(1'b1);
        foreach (directed_rows[i]) begin
            send_item(directed_rows[i].seq, directed_rows[i].payload,
                      directed_rows[i].typed, directed_rows[i].want);
            idle_gap();
        end
        settle();

        // Silent in-order run, back to back.
        set_delivery(1'b0);
        sink_stalls <= 1'b0;
        source_gaps  = 1'b0;
        repeat (16) begin
            send_item(next_seq, random_payload(), 1'b0, '0);
        end
        settle();

        // Random traffic with delivery on, then off, then on again.
        set_delivery(1'b1);
        sink_stalls <= 1'b1;
        source_gaps  = 1'b1;
        random_phase(50);
        settle();
        set_delivery(1'b0);
        random_phase(20);
        settle();
        set_delivery(1'b1);
        random_phase(30);
        settle();

        faults = faults + awaited_results.size();
        $display("ran %0d items, %0d of them directed; checked %0d results, %0d rejects",
                 items_sent, $size(directed_rows), results_seen, rejects_seen);
        $display("sequence space wrapped %0d time(s); delivery both off and on", seq_wraps);
        if (faults == 0) begin
            $display("sequence_reorder_buffer regression: pass");
        end else begin
            $display("sequence_reorder_buffer regression: fail");
        end
        $finish;
    end

endmodule
